// ===== sv/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, types and the reset value of the modulus register for the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

   // field widths
   localparam int MOD_W  = 31;
   localparam int BASE_W = 63;
   localparam int EXP_W  = 63;

   // one residue modulo the configured modulus
   typedef logic [MOD_W-1:0] mod_type;

   // modulus after reset
   localparam mod_type MOD_RESET = 31'd1000000007;

endpackage

// ===== sv/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply: power = base ** exponent mod modulus.
// ----------------------------------------------------------------------------
// One item at a time. The base is first reduced bit-serially, then each
// exponent bit up to the highest set one takes a decision step, a pass of
// the two bit-serial modular multipliers, which square and multiply side by
// side, and a handoff step. Only the low EXP_BITS exponent bits are used. A
// modulus below two gives a power of zero. A finished result sits in the
// output register, so the next beat can be taken while it waits. The modulus
// may be written only while idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
   parameter int EXP_BITS = 63
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [modexp_pkg::BASE_W-1:0] req_base,
   input  logic [modexp_pkg::EXP_W-1:0]  req_exponent,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [modexp_pkg::MOD_W-1:0]  rsp_power,
   input  logic                          csr_write_enable,
   input  logic [modexp_pkg::MOD_W-1:0]  csr_write_data
);
   import modexp_pkg::*;

   localparam int SCAN_BITS = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]           state_ff, state_in;
   mod_type              modulus_ff;
   logic [SCAN_BITS-1:0] exp_ff, exp_in;
   mod_type              acc_ff, acc_in;
   mod_type              sq_ff, sq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mod_type              rsp_power_ff, rsp_power_in;
   logic                 accept;
   logic                 red_start;
   logic                 red_done;
   mod_type              red_rem;
   logic                 mul_start;
   logic                 acc_done;
   mod_type              acc_prod;
   logic                 sq_done;
   mod_type              sq_prod;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign red_start = accept && (modulus_ff >= MOD_W'(2));
   assign mul_start = (state_ff == ST_STEP) && (exp_ff != '0);

   // reduce the base once per item whose modulus is two or more
   modexp_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (req_base),
      .modulus   (modulus_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   // running result times current square
   modexp_modmul u_mul_acc (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mult_a  (acc_ff),
      .mult_b  (sq_ff),
      .modulus (modulus_ff),
      .done    (acc_done),
      .product (acc_prod)
   );

   // current square squared
   modexp_modmul u_mul_sq (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mult_a  (sq_ff),
      .mult_b  (sq_ff),
      .modulus (modulus_ff),
      .done    (sq_done),
      .product (sq_prod)
   );

   // sequence reduction, exponent bits and result handoff
   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_power_in = rsp_power_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exp_in = req_exponent[SCAN_BITS-1:0];
               acc_in = MOD_W'(1);
               if (modulus_ff >= MOD_W'(2)) begin
                  state_in = ST_REDUCE;
               end else begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_REDUCE: begin
            if (red_done) begin
               sq_in    = red_rem;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (exp_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (sq_done) begin
               sq_in = sq_prod;
               if (exp_ff[0]) begin
                  acc_in = acc_prod;
               end
               exp_in   = exp_ff >> 1;
               state_in = ST_STEP;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      rsp_power_ff <= rsp_power_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MOD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            modulus_ff <= csr_write_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

`ifndef SYNTHESIS
   // both multipliers start together, so they must finish together
   a_mul_lockstep: assert property (@(posedge clock) disable iff (reset)
      acc_done == sq_done)
      else $error("multiplier done pulses out of step");

   // working residues stay below the modulus
   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_MUL) |-> (acc_ff < modulus_ff && sq_ff < modulus_ff))
      else $error("working residue not reduced");

   // each multiply pass consumes exactly one exponent bit
   a_exp_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && sq_done) |=> (exp_ff == ($past(exp_ff) >> 1)))
      else $error("exponent not advanced by one bit");

   // a delivered power lies below a valid modulus
   a_power_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && modulus_ff >= MOD_W'(2)) |-> (rsp_power_ff < modulus_ff))
      else $error("power out of range");
`endif

endmodule

// ===== sv/modexp_reduce.sv =====
// ----------------------------------------------------------------------------
// modexp_reduce
// Bit-serial reduction of the 63-bit base modulo the modulus: one base bit
// per cycle, most significant first, with one compare and subtract per step.
// ----------------------------------------------------------------------------
module modexp_reduce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [modexp_pkg::BASE_W-1:0] value,
   input  modexp_pkg::mod_type           modulus,
   output logic                          done,
   output modexp_pkg::mod_type           remainder
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(BASE_W);

   logic [BASE_W-1:0] value_ff, value_in;
   mod_type           rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MOD_W:0]    shifted;
   logic [MOD_W:0]    reduced;

   // shift in the next base bit and fold back below the modulus
   always_comb begin
      shifted = {rem_ff, value_ff[BASE_W-1]};
      reduced = (shifted >= {1'b0, modulus}) ? shifted - {1'b0, modulus} : shifted;
   end

   // advance one bit per cycle while busy
   always_comb begin
      value_in = value_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         value_in = value;
         rem_in   = '0;
         cnt_in   = CNT_W'(BASE_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         value_in = {value_ff[BASE_W-2:0], 1'b0};
         rem_in   = reduced[MOD_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/modexp_modmul.sv =====
// ----------------------------------------------------------------------------
// modexp_modmul
// Bit-serial modular multiplier: scans the multiplier operand one bit per
// cycle, most significant first, doubling and conditionally adding the
// multiplicand, each step kept below the modulus. Operands must be reduced.
// ----------------------------------------------------------------------------
module modexp_modmul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  modexp_pkg::mod_type mult_a,
   input  modexp_pkg::mod_type mult_b,
   input  modexp_pkg::mod_type modulus,
   output logic                done,
   output modexp_pkg::mod_type product
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(MOD_W);

   mod_type          a_ff, a_in;
   mod_type          b_ff, b_in;
   mod_type          acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MOD_W:0]   dbl;
   logic [MOD_W:0]   dbl_red;
   logic [MOD_W:0]   sum;
   logic [MOD_W:0]   sum_red;

   // double, fold, add the multiplicand if the bit is set, fold again
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum     = dbl_red + (b_ff[MOD_W-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
   end

   // advance one multiplier bit per cycle while busy
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = mult_a;
         b_in    = mult_b;
         acc_in  = '0;
         cnt_in  = CNT_W'(MOD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         b_in   = {b_ff[MOD_W-2:0], 1'b0};
         acc_in = sum_red[MOD_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== test/modular_exponentiation_tb.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the square-and-multiply power unit. Operand beats go
// in on the req_ channel with random gaps. Each accepted beat is run through a
// local power predictor under the current modulus. Every rsp_ beat is checked
// in order against the queue of predicted powers. The modulus register is
// rewritten between phases, only while nothing is in flight.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
   import modexp_pkg::*;

   localparam int EXP_BITS = 63;
   localparam int IDLE_PCT = 21;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
   localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};
   localparam mod_type MOD_MAX = {MOD_W{1'b1}};

   // modulus families used by the random phases
   typedef enum int {
      MOD_FULL_RANGE,
      MOD_TINY,
      MOD_POW2,
      MOD_NEAR_TOP
   } mod_family_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BASE_W-1:0] req_base = '0;
   logic [EXP_W-1:0]  req_exponent = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [MOD_W-1:0] rsp_power;
   logic csr_write_enable = 1'b0;
   logic [MOD_W-1:0] csr_write_data = '0;

   mod_type power_queue[$];
   mod_type active_modulus = MOD_RESET;
   mod_type popped_power;
   bit steady_flow = 1'b0;
   int failures = 0;
   int powers_checked = 0;
   int modulus_settings = 1;
   int cycle_count = 0;

   modular_exponentiation #(
      .EXP_BITS(EXP_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_base(req_base),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power(rsp_power),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // guard against a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // throttle the result side
   always @(negedge clock) begin
      rsp_ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   // ------------------------------------------------------------------------
   // power predictor
   // ------------------------------------------------------------------------
   function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] m);
      logic [63:0] ra;
      logic [63:0] rb;
      ra = a % m;
      rb = b % m;
      return (ra * rb) % m;
   endfunction

   function automatic mod_type predict_power(logic [BASE_W-1:0] b,
                                             logic [EXP_W-1:0] e, mod_type m);
      logic [63:0] mm;
      logic [63:0] acc;
      logic [63:0] sq;
      if (m < 2) return '0;
      mm = {33'd0, m};
      acc = 64'd1 % mm;
      sq = {1'b0, b} % mm;
      // scan the exponent from bit 0 upward
      for (int i = 0; i < EXP_BITS; i++) begin
         if (e[i]) acc = mul_reduce(acc, sq, mm);
         sq = mul_reduce(sq, sq, mm);
      end
      return acc[MOD_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (power_queue.size() == 0) begin
            $error("rsp beat with nothing predicted: power actual %0d", rsp_power);
            failures++;
         end else begin
            popped_power = power_queue.pop_front();
            powers_checked++;
            if (rsp_power !== popped_power) begin
               $error("power mismatch: expected %0d, actual %0d", popped_power,
                      rsp_power);
               failures++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // shared drivers
   // ------------------------------------------------------------------------
   // send one operand beat, with random idle cycles ahead of it
   task automatic send_operands(input logic [BASE_W-1:0] b,
                                input logic [EXP_W-1:0] e);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_base <= b;
      req_exponent <= e;
      do @(posedge clock); while (!req_ready);
      power_queue.insert(power_queue.size(), predict_power(b, e, active_modulus));
   endtask

   // drop valid and wait until every predicted power has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (power_queue.size() != 0) @(negedge clock);
   endtask

   // write the modulus register once the block is idle
   task automatic set_modulus(input mod_type m);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      active_modulus = m;
      modulus_settings++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [BASE_W-1:0] random_base(mod_type m);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(9))
         0: return {32'd0, m} - 63'd1;
         1: return {32'd0, m} * BASE_W'($urandom_range(0, 1000));
         2: return BASE_W'($urandom_range(0, 3));
         default: return r[BASE_W-1:0];
      endcase
   endfunction

   // mostly short exponents keep latency down; some use all 63 bits
   function automatic logic [EXP_W-1:0] random_exponent();
      logic [63:0] r;
      int w;
      r = {$urandom, $urandom};
      if ($urandom_range(99) < 15) return r[EXP_W-1:0];
      w = $urandom_range(0, 10);
      return r[EXP_W-1:0] & ((63'd1 << w) - 63'd1);
   endfunction

   function automatic mod_type random_modulus(mod_family_type fam);
      case (fam)
         MOD_TINY:     return MOD_W'($urandom_range(2, 64));
         MOD_POW2:     return 31'd1 << $urandom_range(1, 30);
         MOD_NEAR_TOP: return MOD_MAX - MOD_W'($urandom_range(0, 1000));
         default:      return MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
      endcase
   endfunction

   task automatic send_random_items(input int count);
      for (int i = 0; i < count; i++) begin
         send_operands(random_base(active_modulus), random_exponent());
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // corner operands under the modulus left by reset
   task automatic test_reset_modulus();
      send_operands('0, '0);
      send_operands('0, 63'd1);
      send_operands(BASE_MAX, '0);
      send_operands(BASE_MAX, EXP_MAX);
      send_operands(63'd1, EXP_MAX);
      send_operands(63'd2, 63'd10);
      send_operands({32'd0, MOD_RESET}, 63'd3);
      send_operands({32'd0, MOD_RESET} + 63'd1, EXP_MAX);
      send_operands(63'd1 << 62, 63'd1 << 62);
      send_operands({32'd0, MOD_RESET} - 63'd1, 63'd2);
      // Fermat inverse of 3
      send_operands(63'd3, {32'd0, MOD_RESET} - 63'd2);
   endtask

   // smallest and largest legal modulus
   task automatic test_modulus_extremes();
      set_modulus(31'd2);
      send_operands(BASE_MAX, 63'd1);
      send_operands(63'd2, 63'd5);
      send_operands(63'd7, '0);
      set_modulus(MOD_MAX);
      send_operands(BASE_MAX, EXP_MAX);
      send_operands({32'd0, MOD_MAX} - 63'd1, 63'd2);
      send_operands({32'd0, MOD_MAX}, 63'd1);
   endtask

   // modulus of zero or one forces every power to zero
   task automatic test_degenerate_modulus();
      set_modulus(31'd0);
      send_operands(63'd5, '0);
      send_operands(BASE_MAX, EXP_MAX);
      set_modulus(31'd1);
      send_operands(63'd7, '0);
      send_operands(63'd3, 63'd9);
   endtask

   // random operands across a spread of modulus families
   task automatic test_random_phases();
      mod_family_type fam;
      for (int phase = 0; phase < 8; phase++) begin
         fam = mod_family_type'(phase % 4);
         set_modulus(random_modulus(fam));
         send_random_items(120);
      end
   endtask

   // back-to-back beats with both sides always ready
   task automatic test_back_to_back();
      set_modulus(MOD_RESET);
      steady_flow = 1'b1;
      send_random_items(150);
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_modulus();
      test_modulus_extremes();
      test_degenerate_modulus();
      test_random_phases();
      test_back_to_back();

      // let the last result settle and watch for strays
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (power_queue.size() != 0) begin
         $error("%0d predicted powers never arrived", power_queue.size());
         failures++;
      end

      $display("Checked %0d powers over %0d modulus settings, %0d failures.",
               powers_checked, modulus_settings, failures);
      $display("Covered zero and full-width exponents, moduli 0 to 2^31-1, stalls.");
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
